FILE: src/wlf_pkg.sv
`default_nettype none

package wlf_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CNT_W       = 6;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [BYTE_W-1:0] NUL_CHAR   = 8'h00;
    localparam logic [BYTE_W-1:0] TAB_CHAR   = 8'h09;
    localparam logic [BYTE_W-1:0] CR_CHAR    = 8'h0D;

    // at most one command per accepted byte: separator, held word, one byte, terminator
    typedef struct packed {
        logic              sep;
        logic [CNT_W-1:0]  cnt;
        logic              byte_v;
        logic [BYTE_W-1:0] byte_val;
        logic              byte_last;
        logic              zero_end;
    } cmd_t;

    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        return b inside {SPACE_CHAR, [TAB_CHAR:CR_CHAR]};
    endfunction

    function automatic logic cmd_empty(input cmd_t c);
        return !c.sep && (c.cnt == '0) && !c.byte_v && !c.zero_end;
    endfunction

endpackage

`default_nettype wire

FILE: src/wlf_ram.sv
`default_nettype none

module wlf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/wlf_front.sv
`default_nettype none

module wlf_front
    import wlf_pkg::*;
#(
    parameter int unsigned MAX_DROP_LENGTH = 32,
    localparam int unsigned AW = (MAX_DROP_LENGTH > 1) ? $clog2(MAX_DROP_LENGTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [CNT_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] text_byte,
    input  wire logic              final_byte,
    input  wire logic              q_ready,
    output logic                   q_push,
    output cmd_t                   q_cmd,
    input  wire logic              flush_done,
    output logic                   st_we,
    output logic      [AW-1:0]     st_addr,
    output logic      [BYTE_W-1:0] st_data
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DROP_LENGTH);

    logic [CNT_W-1:0] drop_len_reg;
    logic [CNT_W-1:0] held_reg, held_next, held_mid;
    logic             str_reg, str_next, str_mid;
    logic             nky_reg, nky_next, nky_mid;
    logic             flush_pend_reg, flush_pend_next;
    logic             accept, ending, store_byte;
    cmd_t             cmd;

    assign in_stall = !q_ready || flush_pend_reg;
    assign accept   = in_valid && !in_stall;
    assign ending   = (text_byte == NUL_CHAR) || final_byte;

    // classify the byte against the word state
    always_comb
    begin
        cmd          = '0;
        cmd.byte_val = text_byte;
        held_mid     = held_reg;
        str_mid      = str_reg;
        nky_mid      = nky_reg;
        store_byte   = 1'b0;
        if (drop_len_reg == '0)
        begin
            cmd.byte_v    = 1'b1;
            cmd.byte_last = ending;
        end
        else
        begin
            if (text_byte != NUL_CHAR)
            begin
                if (is_space(text_byte))
                begin
                    if ((held_reg != '0) && (held_reg != drop_len_reg))
                    begin
                        cmd.sep = !nky_reg;
                        cmd.cnt = held_reg;
                        nky_mid = 1'b0;
                    end
                    held_mid = '0;
                    str_mid  = 1'b0;
                end
                else if (str_reg)
                begin
                    cmd.byte_v = 1'b1;
                end
                else if ((held_reg < MAX_CNT) && (held_reg < drop_len_reg))
                begin
                    store_byte = 1'b1;
                    held_mid   = held_reg + CNT_W'(1);
                end
                else
                begin
                    cmd.sep    = !nky_reg;
                    cmd.cnt    = held_reg;
                    cmd.byte_v = 1'b1;
                    nky_mid    = 1'b0;
                    held_mid   = '0;
                    str_mid    = 1'b1;
                end
            end
            if (ending)
            begin
                if ((held_mid != '0) && (held_mid != drop_len_reg))
                begin
                    cmd.sep = !nky_mid;
                    cmd.cnt = held_mid;
                end
                // full store plus separator plus byte: terminator replaces the byte
                if (cmd.byte_v && cmd.sep && (cmd.cnt == MAX_CNT))
                begin
                    cmd.byte_v = 1'b0;
                end
                cmd.zero_end = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (ending)
        begin
            held_next = '0;
            str_next  = 1'b0;
            nky_next  = 1'b1;
        end
        else
        begin
            held_next = held_mid;
            str_next  = str_mid;
            nky_next  = nky_mid;
        end
    end

    assign q_push  = accept && !cmd_empty(cmd);
    assign q_cmd   = cmd;
    assign st_we   = accept && store_byte;
    assign st_addr = held_reg[AW-1:0];
    assign st_data = text_byte;

    always_comb
    begin
        flush_pend_next = flush_pend_reg;
        if (q_push && (cmd.cnt != '0))
        begin
            flush_pend_next = 1'b1;
        end
        else if (flush_done)
        begin
            flush_pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_len_reg   <= '0;
            held_reg       <= '0;
            str_reg        <= 1'b0;
            nky_reg        <= 1'b1;
            flush_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                drop_len_reg <= cfg_data;
            end
            if (accept)
            begin
                held_reg <= held_next;
                str_reg  <= str_next;
                nky_reg  <= nky_next;
            end
            flush_pend_reg <= flush_pend_next;
        end
    end

`ifndef SYNTH
    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> (held_reg < MAX_CNT))
        else $error("word store written past its depth");

    a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && (cmd.cnt != '0)) |=> flush_pend_reg)
        else $error("flush issued without holding off input");
`endif

endmodule

`default_nettype wire

FILE: src/wlf_queue.sv
`default_nettype none

module wlf_queue
    import wlf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      ready,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;

    assign ready      = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != FULL_CNT))
        else $error("command queue overflow");
`endif

endmodule

`default_nettype wire

FILE: src/wlf_back.sv
`default_nettype none

module wlf_back
    import wlf_pkg::*;
#(
    parameter int unsigned MAX_DROP_LENGTH = 32,
    localparam int unsigned AW = (MAX_DROP_LENGTH > 1) ? $clog2(MAX_DROP_LENGTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  cmd_t                   q_cmd,
    output logic                   rd_en,
    output logic      [AW-1:0]     rd_addr,
    input  wire logic [BYTE_W-1:0] rd_data,
    output logic                   flush_done,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [BYTE_W-1:0] out_byte,
    output logic                   out_last
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SEP  = 6'b000010,
        S_RD   = 6'b000100,
        S_DAT  = 6'b001000,
        S_BYTE = 6'b010000,
        S_ZERO = 6'b100000
    } back_state_t;

    function automatic back_state_t first_state(input cmd_t c);
        back_state_t s;
        if (c.sep)
        begin
            s = S_SEP;
        end
        else if (c.cnt != '0)
        begin
            s = S_RD;
        end
        else if (c.byte_v)
        begin
            s = S_BYTE;
        end
        else
        begin
            s = S_ZERO;
        end
        return s;
    endfunction

    back_state_t       state_reg, state_next;
    back_state_t       after_sep, after_dat, after_byte;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_free, emit;

    assign out_free = !out_valid_reg || !out_stall;

    // remaining phases of the current command
    assign after_byte = cmd_reg.zero_end ? S_ZERO : S_IDLE;
    assign after_dat  = cmd_reg.byte_v ? S_BYTE : after_byte;
    assign after_sep  = (cmd_reg.cnt != '0) ? S_RD : after_dat;

    assign rd_addr = idx_reg[AW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        emit          = 1'b0;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        rd_en         = 1'b0;
        flush_done    = 1'b0;
        q_pop         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                state_next = S_IDLE;
            end
            S_SEP:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = SPACE_CHAR;
                    out_last_next = 1'b0;
                    state_next    = after_sep;
                end
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_DAT;
            end
            S_DAT:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = rd_data;
                    out_last_next = 1'b0;
                    idx_next      = idx_reg + CNT_W'(1);
                    if ((idx_reg + CNT_W'(1)) == cmd_reg.cnt)
                    begin
                        flush_done = 1'b1;
                        state_next = after_dat;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_BYTE:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = cmd_reg.byte_val;
                    out_last_next = cmd_reg.byte_last;
                    state_next    = after_byte;
                end
            end
            S_ZERO:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = NUL_CHAR;
                    out_last_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // command done: pick up the next one in the same cycle
        if ((state_next == S_IDLE) && q_valid)
        begin
            q_pop      = 1'b1;
            cmd_next   = q_cmd;
            idx_next   = '0;
            state_next = first_state(q_cmd);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTH
    a_dat_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DAT) |-> ($past(state_reg) == S_RD || $past(state_reg) == S_DAT))
        else $error("word byte taken without a store read");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !cmd_empty(q_cmd))
        else $error("empty command reached the output sequencer");
`endif

endmodule

`default_nettype wire

FILE: src/word_length_filter.sv
// word_length_filter removes every word of one length from a byte stream of text.
// text comes in one byte per transfer on in_valid/in_stall (text_byte, final_byte);
// kept words leave on out_valid/out_stall joined by single spaces, and a zero
// byte or a byte with final_byte set closes the text with a terminating zero
// flagged out_last (with drop_length 0, that byte itself is flagged out_last).
// drop_length must be written through cfg_write/cfg_data only while the block
// is idle; the block itself does not enforce this. 0 passes every byte through
// unchanged. a front stage classifies each byte, keeps the word state and writes
// word bytes into a MAX_DROP_LENGTH entry word store; a two-entry command queue
// feeds an output sequencer that emits separators, held words, streamed bytes
// and terminators. a held word is flushed as a separator where one is due, then
// for each byte a store read followed by an output load; input is held off
// until the last byte of that flush has left the store for the output register.
// the word store needs no clearing after reset.

`default_nettype none

module word_length_filter
    import wlf_pkg::*;
#(
    parameter int unsigned MAX_DROP_LENGTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    // configuration: drop length register
    input  wire logic              cfg_write,
    input  wire logic [CNT_W-1:0]  cfg_data,

    // input text bytes
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] text_byte,
    input  wire logic              final_byte,

    // filtered text bytes
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [BYTE_W-1:0] out_byte,
    output logic                   out_last
);

    localparam int unsigned AW = (MAX_DROP_LENGTH > 1) ? $clog2(MAX_DROP_LENGTH) : 1;

    // front to queue
    logic              q_push, q_ready;
    cmd_t              q_in_cmd;

    // queue to back
    logic              q_valid, q_pop;
    cmd_t              q_head_cmd;

    // word store ports
    logic              st_we;
    logic [AW-1:0]     st_addr;
    logic [BYTE_W-1:0] st_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;

    // back tells front the held word has been read out
    logic              flush_done;

    wlf_front #(
        .MAX_DROP_LENGTH (MAX_DROP_LENGTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_cmd      (q_in_cmd),
        .flush_done (flush_done),
        .st_we      (st_we),
        .st_addr    (st_addr),
        .st_data    (st_data)
    );

    wlf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_DROP_LENGTH)
    ) u_word_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_addr),
        .wdata (st_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    wlf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_in_cmd),
        .ready      (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head_cmd)
    );

    wlf_back #(
        .MAX_DROP_LENGTH (MAX_DROP_LENGTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_cmd      (q_head_cmd),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .flush_done (flush_done),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

`ifndef SYNTH
    a_store_quiet_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !st_we)
        else $error("word store written while a held word is read out");
`endif

endmodule

`default_nettype wire
